// ----- rtl/sstw_pkg.sv -----
// ----------------------------------------------------------------------------
// sstw_pkg
// Types, command bytes and the segment lookup for the two-wire
// seven-segment display driver.
// ----------------------------------------------------------------------------
package sstw_pkg;

  localparam int unsigned NumberWidth = 14;
  localparam logic [NumberWidth-1:0] MaxNumber = 14'd9999;

  localparam logic [7:0] MODE_CMD = 8'h40;
  localparam logic [7:0] ADDR_CMD = 8'hC0;
  localparam logic [7:0] CTRL_CMD = 8'h80;

  localparam logic [1:0] FRAME_MODE   = 2'd0;
  localparam logic [1:0] FRAME_DIGITS = 2'd1;
  localparam logic [1:0] FRAME_CTRL   = 2'd2;

  localparam logic [2:0] LAST_DIGIT_BYTE = 3'd4;

  localparam logic CFG_BRIGHTNESS = 1'b0;
  localparam logic CFG_ENABLE     = 1'b1;

  typedef enum logic [1:0] {
    STAT_NONE,
    STAT_ACCEPTED,
    STAT_RANGE,
    STAT_BUSY
  } status_t;

  typedef struct packed {
    logic    clock_pin;
    logic    data_pin;
    logic    busy;
    status_t status;
  } result_t;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/seven_segment_two_wire_display_driver.sv -----
// ----------------------------------------------------------------------------
// seven_segment_two_wire_display_driver
// Splits a number into four decimal digits and drives the two-wire display
// protocol, one pin write for each input beat.
// ----------------------------------------------------------------------------
// The result beat for an input beat is registered in the output queue and offered from its head.
// Throughput: one input beat per cycle unless the two-entry output queue is
// full (tick_stall); the queue keeps input flowing while a result beat is held.
// A display transfer is 210 beats; the decimal split is done in the accepting cycle.
// Reset: idle, both pin levels low, brightness level 1, display enabled, queue empty.
module seven_segment_two_wire_display_driver (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick_valid,
  output logic        tick_stall,
  input  logic        request_valid,
  input  logic [13:0] number,
  output logic        pin_valid,
  input  logic        pin_stall,
  output logic        clock_pin,
  output logic        data_pin,
  output logic        busy_res,
  output logic [1:0]  request_status,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data
);

  typedef enum logic [1:0] {
    PART_START,
    PART_BYTE,
    PART_ACK,
    PART_STOP
  } part_t;

  logic [2:0] brightness_level;
  logic       display_enable;

  logic       active;
  logic [1:0] frame;
  part_t      part;
  logic [1:0] sub;
  logic [2:0] bit_idx;
  logic [2:0] byte_idx;
  logic       clock_level;
  logic       data_level;

  logic       active_next;
  logic [1:0] frame_next;
  part_t      part_next;
  logic [1:0] sub_next;
  logic [2:0] bit_idx_next;
  logic [2:0] byte_idx_next;
  logic       clock_level_next;
  logic       data_level_next;

  logic [1:0] cur_frame;
  part_t      cur_part;
  logic [1:0] cur_sub;
  logic [2:0] cur_bit;
  logic [2:0] cur_byte;
  logic [2:0] last_byte;
  logic [7:0] byte_val;
  logic [3:0] digit;

  logic [27:0] prod_th;
  logic [27:0] prod_hu;
  logic [27:0] prod_te;
  logic [6:0]  hu_all;
  logic [9:0]  te_all;
  logic [3:0]  digit_th;
  logic [3:0]  digit_hu;
  logic [3:0]  digit_te;
  logic [3:0]  digit_one;
  logic [3:0]  digit_store [4];

  sstw_pkg::result_t res_q [2];
  sstw_pkg::result_t res_new;
  sstw_pkg::status_t status;
  logic [1:0] q_count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;
  logic       pop;
  logic       start;
  logic       run;

  assign tick_stall = (q_count == 2'd2);
  assign pin_valid  = (q_count != 2'd0);
  assign push       = tick_valid && !tick_stall;
  assign pop        = pin_valid && !pin_stall;

  assign clock_pin      = res_q[rd_ptr].clock_pin;
  assign data_pin       = res_q[rd_ptr].data_pin;
  assign busy_res       = res_q[rd_ptr].busy;
  assign request_status = res_q[rd_ptr].status;

  assign start = request_valid && !active && (number <= sstw_pkg::MaxNumber);
  assign run   = start || active;

  always_comb begin
    if (!request_valid) begin
      status = sstw_pkg::STAT_NONE;
    end else if (active) begin
      status = sstw_pkg::STAT_BUSY;
    end else if (number > sstw_pkg::MaxNumber) begin
      status = sstw_pkg::STAT_RANGE;
    end else begin
      status = sstw_pkg::STAT_ACCEPTED;
    end
  end

  // The quotients by 1000, 100 and 10 come from reciprocal products that are
  // exact for every number up to 9999; each digit is a quotient less ten
  // times the next coarser one.
  always_comb begin
    prod_th   = 28'(number) * 28'd8389;
    prod_hu   = 28'(number) * 28'd5243;
    prod_te   = 28'(number) * 28'd6554;
    hu_all    = prod_hu[25:19];
    te_all    = prod_te[25:16];
    digit_th  = prod_th[26:23];
    digit_hu  = 4'(hu_all - {digit_th, 3'b000} - {2'b00, digit_th, 1'b0});
    digit_te  = 4'(te_all - {hu_all, 3'b000} - {2'b00, hu_all, 1'b0});
    digit_one = 4'(number - {1'b0, te_all, 3'b000} - {3'b000, te_all, 1'b0});
  end

  always_comb begin
    if (start) begin
      cur_frame = sstw_pkg::FRAME_MODE;
      cur_part  = PART_START;
      cur_sub   = 2'd0;
      cur_bit   = 3'd0;
      cur_byte  = 3'd0;
    end else begin
      cur_frame = frame;
      cur_part  = part;
      cur_sub   = sub;
      cur_bit   = bit_idx;
      cur_byte  = byte_idx;
    end
  end

  always_comb begin
    case (cur_byte)
      3'd1:    digit = digit_store[0];
      3'd2:    digit = digit_store[1];
      3'd3:    digit = digit_store[2];
      default: digit = digit_store[3];
    endcase
  end

  always_comb begin
    case (cur_frame)
      sstw_pkg::FRAME_MODE: byte_val = sstw_pkg::MODE_CMD;
      sstw_pkg::FRAME_CTRL: begin
        byte_val = sstw_pkg::CTRL_CMD | {4'b0000, display_enable, brightness_level};
      end
      default: begin
        byte_val = (cur_byte == 3'd0) ? sstw_pkg::ADDR_CMD : sstw_pkg::seg_code(digit);
      end
    endcase
    last_byte = (cur_frame == sstw_pkg::FRAME_DIGITS) ? sstw_pkg::LAST_DIGIT_BYTE : 3'd0;
  end

  always_comb begin
    active_next      = active;
    frame_next       = frame;
    part_next        = part;
    sub_next         = sub;
    bit_idx_next     = bit_idx;
    byte_idx_next    = byte_idx;
    clock_level_next = clock_level;
    data_level_next  = data_level;
    if (run) begin
      active_next   = 1'b1;
      frame_next    = cur_frame;
      part_next     = cur_part;
      sub_next      = cur_sub + 2'd1;
      bit_idx_next  = cur_bit;
      byte_idx_next = cur_byte;
      unique case (cur_part)
        PART_START: begin
          if (cur_sub == 2'd0) begin
            clock_level_next = 1'b1;
          end else begin
            data_level_next = (cur_sub == 2'd1);
          end
          if (cur_sub == 2'd2) begin
            part_next     = PART_BYTE;
            sub_next      = 2'd0;
            bit_idx_next  = 3'd0;
            byte_idx_next = 3'd0;
          end
        end
        PART_BYTE: begin
          if (cur_sub == 2'd0) begin
            clock_level_next = 1'b0;
          end else if (cur_sub == 2'd1) begin
            data_level_next = byte_val[cur_bit];
          end else begin
            clock_level_next = 1'b1;
            sub_next         = 2'd0;
            bit_idx_next     = cur_bit + 3'd1;
            if (cur_bit == 3'd7) begin
              part_next = PART_ACK;
            end
          end
        end
        PART_ACK: begin
          clock_level_next = (cur_sub == 2'd1);
          if (cur_sub == 2'd2) begin
            sub_next     = 2'd0;
            bit_idx_next = 3'd0;
            if (cur_byte == last_byte) begin
              part_next = PART_STOP;
            end else begin
              part_next     = PART_BYTE;
              byte_idx_next = cur_byte + 3'd1;
            end
          end
        end
        PART_STOP: begin
          if (cur_sub == 2'd0) begin
            clock_level_next = 1'b0;
          end else if (cur_sub == 2'd1) begin
            data_level_next = 1'b0;
          end else if (cur_sub == 2'd2) begin
            clock_level_next = 1'b1;
          end else begin
            data_level_next = 1'b1;
            part_next       = PART_START;
            if (cur_frame == sstw_pkg::FRAME_CTRL) begin
              active_next = 1'b0;
              frame_next  = sstw_pkg::FRAME_MODE;
            end else begin
              frame_next = cur_frame + 2'd1;
            end
          end
        end
        default: part_next = PART_START;
      endcase
    end
  end

  always_comb begin
    res_new.clock_pin = clock_level_next;
    res_new.data_pin  = data_level_next;
    res_new.busy      = active_next;
    res_new.status    = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness_level <= 3'd1;
      display_enable   <= 1'b1;
    end else if (cfg_write) begin
      if (cfg_index == sstw_pkg::CFG_BRIGHTNESS) begin
        brightness_level <= cfg_data;
      end else begin
        display_enable <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      frame       <= sstw_pkg::FRAME_MODE;
      part        <= PART_START;
      sub         <= 2'd0;
      bit_idx     <= 3'd0;
      byte_idx    <= 3'd0;
      clock_level <= 1'b0;
      data_level  <= 1'b0;
    end else if (push) begin
      active      <= active_next;
      frame       <= frame_next;
      part        <= part_next;
      sub         <= sub_next;
      bit_idx     <= bit_idx_next;
      byte_idx    <= byte_idx_next;
      clock_level <= clock_level_next;
      data_level  <= data_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && start) begin
      digit_store[0] <= digit_th;
      digit_store[1] <= digit_hu;
      digit_store[2] <= digit_te;
      digit_store[3] <= digit_one;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= 2'd0;
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        q_count <= q_count + 2'd1;
      end else if (pop && !push) begin
        q_count <= q_count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_q[wr_ptr] <= res_new;
    end
  end

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    active |-> digit_store[0] <= 4'd9 && digit_store[1] <= 4'd9 &&
               digit_store[2] <= 4'd9 && digit_store[3] <= 4'd9)
    else $error("stored digit out of decimal range");

  a_transfer_ends: assert property (@(posedge clk) disable iff (rst)
    push && active && part == PART_STOP && sub == 2'd3 && frame == sstw_pkg::FRAME_CTRL
    |=> !active)
    else $error("transfer did not end after the last stop condition");

  a_frame_range: assert property (@(posedge clk) disable iff (rst)
    active |-> frame != 2'd3)
    else $error("frame counter out of range");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count == 2'd2 && !pop |=> q_count == 2'd2 && $stable(wr_ptr))
    else $error("result queue written while full");

endmodule
